// ===== rtl/tslc_pkg.sv =====
// tslc_pkg: shared types, codes and helpers for the slew-limited teleop command block
// used by every module under rtl; depends on nothing

package tslc_pkg;

    // event kinds carried in the input beat
    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_STOP    = 2'd3
    } tslc_kind_t;

    // button codes
    localparam logic [2:0] BTN_FWD   = 3'd0;
    localparam logic [2:0] BTN_REV   = 3'd1;
    localparam logic [2:0] BTN_LEFT  = 3'd2;
    localparam logic [2:0] BTN_RIGHT = 3'd3;
    localparam logic [2:0] BTN_LIFT  = 3'd4;
    localparam logic [2:0] BTN_LOWER = 3'd5;
    localparam logic [2:0] BTN_STOP  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_LINEAR_SPEED_LIMIT  = 3'd0;
    localparam logic [2:0] REG_TURN_SPEED_LIMIT    = 3'd1;
    localparam logic [2:0] REG_LINEAR_ACCEL_PER_MS = 3'd2;
    localparam logic [2:0] REG_TURN_ACCEL_PER_MS   = 3'd3;
    localparam logic [2:0] REG_FORK_RATE_PER_MS    = 3'd4;
    localparam logic [2:0] REG_FORK_LOW_LIMIT      = 3'd5;
    localparam logic [2:0] REG_FORK_HIGH_LIMIT     = 3'd6;
    localparam logic [2:0] REG_FORK_START          = 3'd7;

    // widths
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned ValW = 24;
    localparam int unsigned WideW = 26;
    localparam int unsigned DtW = 8;
    localparam int unsigned StepW = 24;

    // elapsed time saturation, milliseconds
    localparam logic [15:0] DT_CAP_MS = 16'd250;

    // register reset values
    localparam logic [22:0] RST_LINEAR_SPEED_LIMIT  = 23'd131072;
    localparam logic [22:0] RST_TURN_SPEED_LIMIT    = 23'd49152;
    localparam logic [15:0] RST_LINEAR_ACCEL_PER_MS = 16'd66;
    localparam logic [15:0] RST_TURN_ACCEL_PER_MS   = 16'd98;
    localparam logic [15:0] RST_FORK_RATE_PER_MS    = 16'd33;
    localparam logic signed [23:0] RST_FORK_LOW_LIMIT  = 24'sd0;
    localparam logic signed [23:0] RST_FORK_HIGH_LIMIT = 24'sd117965;
    localparam logic signed [23:0] RST_FORK_NOW        = 24'sd0;

    typedef struct packed {
        tslc_kind_t  kind;
        logic [2:0]  button;
        logic        auto_repeat;
        logic [15:0] elapsed_ms;
    } tslc_in_t;

    typedef struct packed {
        logic signed [23:0] linear_velocity;
        logic signed [23:0] angular_velocity;
        logic signed [23:0] fork_target;
        logic               published;
        logic               changed;
    } tslc_out_t;

    typedef struct packed {
        logic [22:0]        linear_speed_limit;
        logic [22:0]        turn_speed_limit;
        logic [15:0]        linear_accel_per_ms;
        logic [15:0]        turn_accel_per_ms;
        logic [15:0]        fork_rate_per_ms;
        logic signed [23:0] fork_low_limit;
        logic signed [23:0] fork_high_limit;
    } tslc_cfg_t;

    typedef struct packed {
        logic               load;
        logic signed [23:0] value;
    } tslc_fork_load_t;

    typedef struct packed {
        logic [5:0]         held;
        logic signed [23:0] lin;
        logic signed [23:0] ang;
        logic signed [23:0] fork_pos;
    } tslc_state_t;

    // clamp a wide fork value, high limit tested first
    function automatic logic signed [23:0] tslc_clamp(input logic signed [25:0] x,
                                                      input logic signed [23:0] lo,
                                                      input logic signed [23:0] hi);
        logic signed [25:0] lo_w;
        logic signed [25:0] hi_w;
        lo_w = signed'({{2{lo[23]}}, lo});
        hi_w = signed'({{2{hi[23]}}, hi});
        if (x > hi_w) begin
            return hi;
        end else if (x < lo_w) begin
            return lo;
        end
        return x[23:0];
    endfunction

endpackage

// ===== rtl/tslc_cfg_regs.sv =====
// tslc_cfg_regs: configuration register file with fork start load
// depends on tslc_pkg

module tslc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tslc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [tslc_pkg::CfgDataW-1:0]   cfg_wr_data,
    output tslc_pkg::tslc_cfg_t             cfg,
    output tslc_pkg::tslc_fork_load_t       fork_load
);
    import tslc_pkg::*;

    tslc_cfg_t cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.linear_speed_limit  <= RST_LINEAR_SPEED_LIMIT;
            cfg_reg.turn_speed_limit    <= RST_TURN_SPEED_LIMIT;
            cfg_reg.linear_accel_per_ms <= RST_LINEAR_ACCEL_PER_MS;
            cfg_reg.turn_accel_per_ms   <= RST_TURN_ACCEL_PER_MS;
            cfg_reg.fork_rate_per_ms    <= RST_FORK_RATE_PER_MS;
            cfg_reg.fork_low_limit      <= RST_FORK_LOW_LIMIT;
            cfg_reg.fork_high_limit     <= RST_FORK_HIGH_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINEAR_SPEED_LIMIT:  cfg_reg.linear_speed_limit  <= cfg_wr_data[22:0];
                REG_TURN_SPEED_LIMIT:    cfg_reg.turn_speed_limit    <= cfg_wr_data[22:0];
                REG_LINEAR_ACCEL_PER_MS: cfg_reg.linear_accel_per_ms <= cfg_wr_data[15:0];
                REG_TURN_ACCEL_PER_MS:   cfg_reg.turn_accel_per_ms   <= cfg_wr_data[15:0];
                REG_FORK_RATE_PER_MS:    cfg_reg.fork_rate_per_ms    <= cfg_wr_data[15:0];
                REG_FORK_LOW_LIMIT:      cfg_reg.fork_low_limit      <= signed'(cfg_wr_data);
                REG_FORK_HIGH_LIMIT:     cfg_reg.fork_high_limit     <= signed'(cfg_wr_data);
                default: begin
                end
            endcase
        end
    end

    // fork start write: clamp into the current limits and load the position
    always_comb begin
        fork_load.load  = cfg_wr_en && (cfg_index == REG_FORK_START);
        fork_load.value = tslc_clamp(signed'({{2{cfg_wr_data[23]}}, cfg_wr_data}),
                                     cfg_reg.fork_low_limit, cfg_reg.fork_high_limit);
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tslc_update.sv =====
// tslc_update: single-pass next state and result for one event beat
// depends on tslc_pkg

module tslc_update (
    input  tslc_pkg::tslc_in_t    in_data,
    input  tslc_pkg::tslc_cfg_t   cfg,
    input  tslc_pkg::tslc_state_t cur,
    output tslc_pkg::tslc_state_t nxt,
    output tslc_pkg::tslc_out_t   result
);
    import tslc_pkg::*;

    // move cur toward tgt by at most step
    function automatic logic signed [WideW-1:0] slew(input logic signed [WideW-1:0] c,
                                                     input logic signed [WideW-1:0] tgt,
                                                     input logic [StepW-1:0] step);
        logic signed [WideW-1:0] step_s;
        logic signed [WideW-1:0] up;
        logic signed [WideW-1:0] dn;
        step_s = signed'({2'b00, step});
        up = c + step_s;
        dn = c - step_s;
        if (c < tgt) begin
            return (up < tgt) ? up : tgt;
        end else if (c > tgt) begin
            return (dn > tgt) ? dn : tgt;
        end
        return tgt;
    endfunction

    // target for a held pair: +limit, -limit or zero
    function automatic logic signed [WideW-1:0] target(input logic plus,
                                                       input logic minus,
                                                       input logic [22:0] limit);
        logic signed [WideW-1:0] lim_w;
        lim_w = signed'({3'b000, limit});
        if (plus && !minus) begin
            return lim_w;
        end else if (minus && !plus) begin
            return -lim_w;
        end
        return '0;
    endfunction

    logic [DtW-1:0]          dt;
    logic [StepW-1:0]        lin_step;
    logic [StepW-1:0]        ang_step;
    logic [StepW-1:0]        fork_step;
    logic signed [WideW-1:0] lin_new;
    logic signed [WideW-1:0] ang_new;
    logic signed [WideW-1:0] fork_w;
    logic signed [WideW-1:0] fork_sum;
    logic                    lift;
    logic                    lower;
    logic                    do_stop;
    logic                    published;

    // saturated tick interval and per-tick steps
    always_comb begin
        dt = (in_data.elapsed_ms > DT_CAP_MS) ? DT_CAP_MS[DtW-1:0] : in_data.elapsed_ms[DtW-1:0];
        lin_step  = StepW'(cfg.linear_accel_per_ms) * StepW'(dt);
        ang_step  = StepW'(cfg.turn_accel_per_ms) * StepW'(dt);
        fork_step = StepW'(cfg.fork_rate_per_ms) * StepW'(dt);
    end

    // slewed velocities and moved fork
    always_comb begin
        lift  = cur.held[BTN_LIFT];
        lower = cur.held[BTN_LOWER];
        lin_new = slew(signed'({{2{cur.lin[23]}}, cur.lin}),
                       target(cur.held[BTN_FWD], cur.held[BTN_REV], cfg.linear_speed_limit),
                       lin_step);
        ang_new = slew(signed'({{2{cur.ang[23]}}, cur.ang}),
                       target(cur.held[BTN_LEFT], cur.held[BTN_RIGHT], cfg.turn_speed_limit),
                       ang_step);
        fork_w = signed'({{2{cur.fork_pos[23]}}, cur.fork_pos});
        if (lift) begin
            fork_sum = fork_w + signed'({2'b00, fork_step});
        end else begin
            fork_sum = fork_w - signed'({2'b00, fork_step});
        end
    end

    // event decode and state update
    always_comb begin
        nxt       = cur;
        do_stop   = 1'b0;
        published = 1'b0;
        case (in_data.kind)
            KIND_PRESS, KIND_RELEASE: begin
                if (!in_data.auto_repeat && in_data.button <= BTN_STOP) begin
                    if (in_data.button == BTN_STOP) begin
                        if (in_data.kind == KIND_PRESS) begin
                            do_stop   = 1'b1;
                            published = 1'b1;
                        end
                    end else if (in_data.kind == KIND_PRESS) begin
                        nxt.held[in_data.button] = 1'b1;
                    end else begin
                        nxt.held[in_data.button] = 1'b0;
                    end
                end
            end
            KIND_TICK: begin
                nxt.lin = lin_new[ValW-1:0];
                nxt.ang = ang_new[ValW-1:0];
                if (lift != lower) begin
                    nxt.fork_pos = tslc_clamp(fork_sum, cfg.fork_low_limit,
                                              cfg.fork_high_limit);
                end
                published = 1'b1;
            end
            default: begin
                do_stop   = 1'b1;
                published = 1'b1;
            end
        endcase
        if (do_stop) begin
            nxt.held = '0;
            nxt.lin  = '0;
            nxt.ang  = '0;
        end
    end

    // result beat
    always_comb begin
        result.linear_velocity  = nxt.lin;
        result.angular_velocity = nxt.ang;
        result.fork_target      = nxt.fork_pos;
        result.published        = published;
        result.changed          = (nxt.lin != cur.lin) || (nxt.ang != cur.ang) ||
                                  (nxt.fork_pos != cur.fork_pos);
    end

endmodule

// ===== rtl/teleop_slew_limited_command.sv =====
// teleop_slew_limited_command: input register, single-pass update, result register
// path: input register, then update logic, then the result register that drives m_valid
// throughput: one beat per cycle while m_ready is high; a low m_ready stalls both registers
// reset: synchronous active-low aresetn; buttons released, velocities and fork zero,
// configuration registers at their default values; depends on tslc_pkg, tslc_cfg_regs, tslc_update

module teleop_slew_limited_command (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tslc_pkg::tslc_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tslc_pkg::tslc_out_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [tslc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [tslc_pkg::CfgDataW-1:0]   cfg_wr_data
);
    import tslc_pkg::*;

    tslc_cfg_t       cfg;
    tslc_fork_load_t fork_load;
    logic            in_valid_reg;
    tslc_in_t        in_data_reg;
    tslc_state_t     state_reg;
    tslc_state_t     state_next;
    logic            out_valid_reg;
    tslc_out_t       out_data_reg;
    tslc_out_t       result;
    logic            advance;

    tslc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg),
        .fork_load   (fork_load)
    );

    tslc_update u_update (
        .in_data (in_data_reg),
        .cfg     (cfg),
        .cur     (state_reg),
        .nxt     (state_next),
        .result  (result)
    );

    // handshake: a beat moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // command state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.held     <= '0;
            state_reg.lin      <= '0;
            state_reg.ang      <= '0;
            state_reg.fork_pos <= RST_FORK_NOW;
        end else if (advance) begin
            state_reg <= state_next;
        end else if (fork_load.load) begin
            state_reg.fork_pos <= fork_load.value;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // a stop event leaves buttons released and both velocities at zero
    a_stop_clears: assert property (@(posedge aclk)
        $past(aresetn) && $past(advance) && $past(in_data_reg.kind) == KIND_STOP |->
        state_reg.held == '0 && state_reg.lin == '0 && state_reg.ang == '0)
        else $error("stop did not clear buttons and velocities");

    // velocities only move when a beat passes through the update
    a_vel_hold: assert property (@(posedge aclk)
        $past(aresetn) && !$past(advance) |->
        state_reg.lin == $past(state_reg.lin) && state_reg.ang == $past(state_reg.ang))
        else $error("velocity moved without a beat");

    // button events that publish nothing cannot change the command
    a_quiet_unchanged: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.published |-> !out_data_reg.changed)
        else $error("unpublished beat reports a change");

    // velocities stay inside the symmetric signed range
    a_vel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.lin != 24'sh800000 && state_reg.ang != 24'sh800000)
        else $error("velocity reached the most negative code");
`endif

endmodule
